// ===== rtl/tcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsm_pkg
// Shared types, codes and helpers of the TCP connection state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcsm_pkg;

    // TCP flag bytes
    localparam logic [7:0] FL_FIN    = 8'h01;
    localparam logic [7:0] FL_SYN    = 8'h02;
    localparam logic [7:0] FL_ACK    = 8'h10;
    localparam logic [7:0] FL_SYNACK = 8'h12;
    localparam logic [7:0] FL_FINACK = 8'h11;

    // event kinds
    localparam logic [1:0] KIND_SEGMENT      = 2'd0;
    localparam logic [1:0] KIND_ACTIVE_OPEN  = 2'd1;
    localparam logic [1:0] KIND_PASSIVE_OPEN = 2'd2;
    localparam logic [1:0] KIND_ACTIVE_CLOSE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ROLE_SERVER  = 2'd0;
    localparam logic [1:0] REG_LOCAL_PORT   = 2'd1;
    localparam logic [1:0] REG_CLIENT_ISEQ  = 2'd2;
    localparam logic [1:0] REG_SERVER_ISEQ  = 2'd3;

    localparam logic [15:0] LOCAL_PORT_RESET = 16'd5678;
    localparam logic [15:0] SYN_WINDOW       = 16'd1;

    // reported connection state codes
    localparam logic [3:0] CODE_CLOSED      = 4'd0;
    localparam logic [3:0] CODE_LISTEN      = 4'd1;
    localparam logic [3:0] CODE_SYN_SENT    = 4'd2;
    localparam logic [3:0] CODE_SYN_RECV    = 4'd3;
    localparam logic [3:0] CODE_ESTABLISHED = 4'd4;
    localparam logic [3:0] CODE_FIN_WAIT_1  = 4'd5;
    localparam logic [3:0] CODE_FIN_WAIT_2  = 4'd6;
    localparam logic [3:0] CODE_CLOSING     = 4'd8;
    localparam logic [3:0] CODE_LAST_ACK    = 4'd10;

    typedef enum logic [8:0] {
        ST_CLOSED      = 9'b000000001,
        ST_LISTEN      = 9'b000000010,
        ST_SYN_SENT    = 9'b000000100,
        ST_SYN_RECV    = 9'b000001000,
        ST_ESTABLISHED = 9'b000010000,
        ST_FIN_WAIT_1  = 9'b000100000,
        ST_FIN_WAIT_2  = 9'b001000000,
        ST_CLOSING     = 9'b010000000,
        ST_LAST_ACK    = 9'b100000000
    } state_t;

    typedef struct packed {
        logic        role_server;
        logic [15:0] local_port;
        logic [31:0] client_iseq;
        logic [31:0] server_iseq;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] seg_src_port;
        logic [15:0] seg_dst_port;
        logic [15:0] peer_port;
        logic [15:0] free_window;
    } event_t;

    typedef struct packed {
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] window;
        logic [3:0]  state_code;
        logic        last;
    } seg_t;

    typedef struct packed {
        state_t      state;
        logic [15:0] remote_port;
        logic [31:0] expected_seq;
        logic [31:0] next_send_seq;
        logic [1:0]  count;
        seg_t        seg0;
        seg_t        seg1;
    } step_t;

    function automatic logic [3:0] state_code(input state_t st);
        logic [3:0] code;
        case (st)
            ST_CLOSED:      code = CODE_CLOSED;
            ST_LISTEN:      code = CODE_LISTEN;
            ST_SYN_SENT:    code = CODE_SYN_SENT;
            ST_SYN_RECV:    code = CODE_SYN_RECV;
            ST_ESTABLISHED: code = CODE_ESTABLISHED;
            ST_FIN_WAIT_1:  code = CODE_FIN_WAIT_1;
            ST_FIN_WAIT_2:  code = CODE_FIN_WAIT_2;
            ST_CLOSING:     code = CODE_CLOSING;
            ST_LAST_ACK:    code = CODE_LAST_ACK;
            default:        code = CODE_CLOSED;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tcsm_event.sv =====
// ----------------------------------------------------------------------------
// tcsm_event
// Decides the next connection state and the segments one event sends.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsm_event (
    input  var tcsm_pkg::state_t st,
    input  var logic [15:0]      remote_port,
    input  var logic [31:0]      expected_seq,
    input  var logic [31:0]      next_send_seq,
    input  var tcsm_pkg::cfg_t   cfg,
    input  var tcsm_pkg::event_t ev,
    output tcsm_pkg::step_t      step
);
    import tcsm_pkg::*;

    logic        is_fin;
    logic        is_ack;
    logic        is_synack;
    logic [31:0] seq_inc;
    logic [31:0] nss_inc;
    seg_t        seg0;
    seg_t        seg1;
    state_t      st_n;
    logic [15:0] rp_n;
    logic [31:0] es_n;
    logic [31:0] ns_n;
    logic [1:0]  cnt;

    assign is_fin    = (ev.seg_flags == FL_FIN) || (ev.seg_flags == FL_FINACK);
    assign is_ack    = (ev.seg_flags == FL_ACK);
    assign is_synack = (ev.seg_flags == FL_SYNACK);
    assign seq_inc   = ev.seg_seq + 32'd1;
    assign nss_inc   = next_send_seq + 32'd1;

    always_comb begin
        st_n = st;
        rp_n = remote_port;
        es_n = expected_seq;
        ns_n = next_send_seq;
        cnt  = 2'd0;
        seg0 = '0;
        seg1 = '0;
        case (ev.kind)
            KIND_ACTIVE_OPEN: begin
                if (st == ST_CLOSED) begin
                    rp_n          = ev.peer_port;
                    seg0.flags    = FL_SYN;
                    seg0.seq      = cfg.client_iseq;
                    seg0.ack      = '0;
                    seg0.src_port = cfg.local_port;
                    seg0.dst_port = ev.peer_port;
                    seg0.window   = SYN_WINDOW;
                    cnt           = 2'd1;
                    st_n          = ST_SYN_SENT;
                end
            end
            KIND_PASSIVE_OPEN: begin
                if (st == ST_CLOSED) begin
                    st_n = ST_LISTEN;
                end
            end
            KIND_ACTIVE_CLOSE: begin
                if (st == ST_ESTABLISHED) begin
                    seg0.flags    = FL_FIN;
                    seg0.seq      = next_send_seq;
                    seg0.ack      = expected_seq;
                    seg0.src_port = cfg.local_port;
                    seg0.dst_port = remote_port;
                    seg0.window   = SYN_WINDOW;
                    cnt           = 2'd1;
                    ns_n          = nss_inc;
                    st_n          = ST_FIN_WAIT_1;
                end
            end
            default: begin
                case (st)
                    ST_LISTEN: begin
                        if (ev.seg_flags == FL_SYN) begin
                            rp_n          = ev.seg_src_port;
                            seg0.flags    = FL_SYNACK;
                            seg0.seq      = cfg.server_iseq;
                            seg0.ack      = seq_inc;
                            seg0.src_port = cfg.local_port;
                            seg0.dst_port = ev.seg_src_port;
                            seg0.window   = SYN_WINDOW;
                            cnt           = 2'd1;
                            st_n          = ST_SYN_RECV;
                        end
                    end
                    ST_SYN_SENT, ST_ESTABLISHED: begin
                        if (is_synack) begin
                            // answer a (repeated) SYN-ACK from its own ports
                            seg0.flags    = FL_ACK;
                            seg0.seq      = ev.seg_ack;
                            seg0.ack      = seq_inc;
                            seg0.src_port = ev.seg_dst_port;
                            seg0.dst_port = ev.seg_src_port;
                            seg0.window   = SYN_WINDOW;
                            cnt           = 2'd1;
                            st_n          = ST_ESTABLISHED;
                        end else if (st == ST_ESTABLISHED && cfg.role_server && is_fin) begin
                            es_n          = seq_inc;
                            seg0.flags    = FL_ACK;
                            seg0.seq      = next_send_seq;
                            seg0.ack      = seq_inc;
                            seg0.src_port = cfg.local_port;
                            seg0.dst_port = remote_port;
                            seg0.window   = ev.free_window;
                            seg1          = seg0;
                            seg1.flags    = FL_FIN;
                            seg1.window   = SYN_WINDOW;
                            cnt           = 2'd2;
                            st_n          = ST_LAST_ACK;
                        end
                    end
                    ST_SYN_RECV: begin
                        if (is_ack) begin
                            st_n = ST_ESTABLISHED;
                        end
                    end
                    ST_FIN_WAIT_1: begin
                        if (is_fin) begin
                            es_n          = seq_inc;
                            seg0.flags    = FL_ACK;
                            seg0.seq      = next_send_seq;
                            seg0.ack      = seq_inc;
                            seg0.src_port = cfg.local_port;
                            seg0.dst_port = remote_port;
                            seg0.window   = ev.free_window;
                            cnt           = 2'd1;
                            ns_n          = nss_inc;
                            st_n          = ST_CLOSING;
                        end else if (is_ack && !cfg.role_server) begin
                            es_n = seq_inc;
                            st_n = ST_FIN_WAIT_2;
                        end
                    end
                    ST_FIN_WAIT_2: begin
                        if (!cfg.role_server && is_fin) begin
                            es_n          = seq_inc;
                            seg0.flags    = FL_ACK;
                            seg0.seq      = next_send_seq;
                            seg0.ack      = seq_inc;
                            seg0.src_port = cfg.local_port;
                            seg0.dst_port = remote_port;
                            seg0.window   = ev.free_window;
                            cnt           = 2'd1;
                            st_n          = ST_CLOSED;
                        end
                    end
                    ST_CLOSING: begin
                        if (is_ack) begin
                            st_n = ST_CLOSED;
                        end
                    end
                    ST_LAST_ACK: begin
                        if (cfg.role_server && is_ack) begin
                            st_n = ST_CLOSED;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
        seg0.state_code = state_code(st_n);
        seg1.state_code = state_code(st_n);
        seg0.last       = (cnt == 2'd1);
        seg1.last       = 1'b1;

        step.state         = st_n;
        step.remote_port   = rp_n;
        step.expected_seq  = es_n;
        step.next_send_seq = ns_n;
        step.count         = cnt;
        step.seg0          = seg0;
        step.seg1          = seg1;
    end

endmodule

`default_nettype wire

// ===== rtl/tcp_connection_state_machine.sv =====
// The first segment of an event is registered and valid in the cycle after the event is taken.
// Throughput: one event per cycle while each sends at most one segment and m_ready
// stays high; an event that sends two segments holds the two-entry output queue
// until both are popped, since a new event is taken only once the queue drains.
// Reset: synchronous, active low; clears the connection state, the output queue
// and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// tcp_connection_state_machine
// Single-connection TCP state machine with a two-entry segment output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_connection_state_machine (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_addr,
    input  wire  [31:0] cfg_wdata,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_kind,
    input  wire  [7:0]  s_seg_flags,
    input  wire  [31:0] s_seg_seq,
    input  wire  [31:0] s_seg_ack,
    input  wire  [15:0] s_seg_src_port,
    input  wire  [15:0] s_seg_dst_port,
    input  wire  [15:0] s_peer_port,
    input  wire  [15:0] s_free_window,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_out_flags,
    output logic [31:0] m_out_seq,
    output logic [31:0] m_out_ack,
    output logic [15:0] m_out_src_port,
    output logic [15:0] m_out_dst_port,
    output logic [15:0] m_out_window,
    output logic [3:0]  m_conn_state_now,
    output logic        m_last
);
    import tcsm_pkg::*;

    cfg_t        cfg_reg;
    state_t      state_reg;
    logic [15:0] remote_port_reg;
    logic [31:0] expected_seq_reg;
    logic [31:0] next_send_seq_reg;
    seg_t        slot0_reg;
    seg_t        slot1_reg;
    logic [1:0]  count_reg;

    event_t ev;
    step_t  step;
    logic   accept;
    logic   pop;

    assign ev.kind         = s_kind;
    assign ev.seg_flags    = s_seg_flags;
    assign ev.seg_seq      = s_seg_seq;
    assign ev.seg_ack      = s_seg_ack;
    assign ev.seg_src_port = s_seg_src_port;
    assign ev.seg_dst_port = s_seg_dst_port;
    assign ev.peer_port    = s_peer_port;
    assign ev.free_window  = s_free_window;

    tcsm_event u_event (
        .st            (state_reg),
        .remote_port   (remote_port_reg),
        .expected_seq  (expected_seq_reg),
        .next_send_seq (next_send_seq_reg),
        .cfg           (cfg_reg),
        .ev            (ev),
        .step          (step)
    );

    assign m_valid = (count_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    // take an event only when the queue is empty after this cycle's pop
    assign s_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);
    assign accept  = s_valid && s_ready;

    assign m_out_flags      = slot0_reg.flags;
    assign m_out_seq        = slot0_reg.seq;
    assign m_out_ack        = slot0_reg.ack;
    assign m_out_src_port   = slot0_reg.src_port;
    assign m_out_dst_port   = slot0_reg.dst_port;
    assign m_out_window     = slot0_reg.window;
    assign m_conn_state_now = slot0_reg.state_code;
    assign m_last           = slot0_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.role_server <= 1'b0;
            cfg_reg.local_port  <= LOCAL_PORT_RESET;
            cfg_reg.client_iseq <= '0;
            cfg_reg.server_iseq <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ROLE_SERVER: cfg_reg.role_server <= cfg_wdata[0];
                REG_LOCAL_PORT:  cfg_reg.local_port  <= cfg_wdata[15:0];
                REG_CLIENT_ISEQ: cfg_reg.client_iseq <= cfg_wdata;
                REG_SERVER_ISEQ: cfg_reg.server_iseq <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLOSED;
            remote_port_reg   <= '0;
            expected_seq_reg  <= '0;
            next_send_seq_reg <= '0;
        end else if (accept) begin
            state_reg         <= step.state;
            remote_port_reg   <= step.remote_port;
            expected_seq_reg  <= step.expected_seq;
            next_send_seq_reg <= step.next_send_seq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (accept) begin
            count_reg <= step.count;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot0_reg <= step.seg0;
            slot1_reg <= step.seg1;
        end else if (pop) begin
            // advance the second segment to the head
            slot0_reg <= slot1_reg;
        end
    end

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("connection state lost its one-hot encoding");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("output queue overfilled");

    a_not_last_has_follower: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (count_reg == 2'd2))
        else $error("non-final segment without a following segment");

    a_pair_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && step.count == 2'd2) |=> (m_valid && !m_last && slot1_reg.last))
        else $error("two-segment transaction not queued in order");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the single-connection TCP state machine: directed
// handshakes and closes at reset settings, then random event streams under
// several role, port and initial-sequence settings, all scored per segment.
// ----------------------------------------------------------------------------

module tb;
    import tcsm_pkg::*;

    localparam int          FROM_MODEL    = -1;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASES        = 5;
    localparam int unsigned PHASE_EVENTS  = 130;
    localparam int unsigned NOISE_PCT     = 15;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef struct {
        event_t     ev;
        int         n_typed;
        logic [3:0] state;
        seg_t       seg;
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [7:0]  s_seg_flags;
    logic [31:0] s_seg_seq;
    logic [31:0] s_seg_ack;
    logic [15:0] s_seg_src_port;
    logic [15:0] s_seg_dst_port;
    logic [15:0] s_peer_port;
    logic [15:0] s_free_window;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_flags;
    logic [31:0] m_out_seq;
    logic [31:0] m_out_ack;
    logic [15:0] m_out_src_port;
    logic [15:0] m_out_dst_port;
    logic [15:0] m_out_window;
    logic [3:0]  m_conn_state_now;
    logic        m_last;

    // connection model
    cfg_t        cfg_now;
    logic [3:0]  conn_code;
    logic [15:0] remote_port_m;
    logic [31:0] rcv_expected;
    logic [31:0] snd_next;
    seg_t        step_out [0:1];
    int unsigned step_count;

    seg_t        segs_due [$];
    plan_row_t   plan [$];

    int unsigned events_sent  = 0;
    int unsigned pairs_seen   = 0;
    int unsigned segs_checked = 0;
    int unsigned errors       = 0;
    int unsigned cycles       = 0;
    int unsigned rx_hold      = 0;
    int unsigned rx_stall;
    bit          tx_quiet     = 1'b0;
    bit          rx_quiet     = 1'b0;

    tcp_connection_state_machine dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_seg_flags      (s_seg_flags),
        .s_seg_seq        (s_seg_seq),
        .s_seg_ack        (s_seg_ack),
        .s_seg_src_port   (s_seg_src_port),
        .s_seg_dst_port   (s_seg_dst_port),
        .s_peer_port      (s_peer_port),
        .s_free_window    (s_free_window),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_flags      (m_out_flags),
        .m_out_seq        (m_out_seq),
        .m_out_ack        (m_out_ack),
        .m_out_src_port   (m_out_src_port),
        .m_out_dst_port   (m_out_dst_port),
        .m_out_window     (m_out_window),
        .m_conn_state_now (m_conn_state_now),
        .m_last           (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic seg_t make_seg(input logic [7:0] flags, input logic [31:0] seq,
                                      input logic [31:0] ack, input logic [15:0] src,
                                      input logic [15:0] dst, input logic [15:0] win);
        seg_t s;
        s = '0;
        s.flags    = flags;
        s.seq      = seq;
        s.ack      = ack;
        s.src_port = src;
        s.dst_port = dst;
        s.window   = win;
        return s;
    endfunction

    function automatic event_t make_event(input logic [1:0] kind, input logic [7:0] flags,
                                          input logic [31:0] seq, input logic [31:0] ack,
                                          input logic [15:0] src, input logic [15:0] dst,
                                          input logic [15:0] peer, input logic [15:0] fwin);
        event_t ev;
        ev.kind         = kind;
        ev.seg_flags    = flags;
        ev.seg_seq      = seq;
        ev.seg_ack      = ack;
        ev.seg_src_port = src;
        ev.seg_dst_port = dst;
        ev.peer_port    = peer;
        ev.free_window  = fwin;
        return ev;
    endfunction

    // Advance the connection by one event; leaves the segments it sends in step_out.
    function automatic void step_connection(input event_t ev);
        logic        is_fin;
        logic        is_ack;
        int unsigned n;
        n      = 0;
        is_fin = (ev.seg_flags == FL_FIN) || (ev.seg_flags == FL_FINACK);
        is_ack = (ev.seg_flags == FL_ACK);
        case (ev.kind)
            KIND_ACTIVE_OPEN: if (conn_code == CODE_CLOSED) begin
                remote_port_m = ev.peer_port;
                step_out[0]   = make_seg(FL_SYN, cfg_now.client_iseq, '0, cfg_now.local_port,
                                         ev.peer_port, SYN_WINDOW);
                n         = 1;
                conn_code = CODE_SYN_SENT;
            end
            KIND_PASSIVE_OPEN: if (conn_code == CODE_CLOSED) begin
                conn_code = CODE_LISTEN;
            end
            KIND_ACTIVE_CLOSE: if (conn_code == CODE_ESTABLISHED) begin
                step_out[0] = make_seg(FL_FIN, snd_next, rcv_expected, cfg_now.local_port,
                                       remote_port_m, SYN_WINDOW);
                n         = 1;
                snd_next  = snd_next + 32'd1;
                conn_code = CODE_FIN_WAIT_1;
            end
            default: begin
                // opening handshake
                if (conn_code == CODE_LISTEN) begin
                    if (ev.seg_flags == FL_SYN) begin
                        remote_port_m = ev.seg_src_port;
                        step_out[0]   = make_seg(FL_SYNACK, cfg_now.server_iseq,
                                                 ev.seg_seq + 32'd1, cfg_now.local_port,
                                                 ev.seg_src_port, SYN_WINDOW);
                        n         = 1;
                        conn_code = CODE_SYN_RECV;
                    end
                end else if (conn_code == CODE_SYN_SENT || conn_code == CODE_ESTABLISHED) begin
                    if (ev.seg_flags == FL_SYNACK) begin
                        step_out[0] = make_seg(FL_ACK, ev.seg_ack, ev.seg_seq + 32'd1,
                                               ev.seg_dst_port, ev.seg_src_port, SYN_WINDOW);
                        n         = 1;
                        conn_code = CODE_ESTABLISHED;
                    end
                end else if (conn_code == CODE_SYN_RECV && is_ack) begin
                    conn_code = CODE_ESTABLISHED;
                end

                // closing rules see the state the handshake just reached
                if (n == 0) begin
                    if (conn_code == CODE_FIN_WAIT_1) begin
                        if (is_fin) begin
                            rcv_expected = ev.seg_seq + 32'd1;
                            step_out[0]  = make_seg(FL_ACK, snd_next, rcv_expected,
                                                    cfg_now.local_port, remote_port_m,
                                                    ev.free_window);
                            n         = 1;
                            snd_next  = snd_next + 32'd1;
                            conn_code = CODE_CLOSING;
                        end else if (is_ack && !cfg_now.role_server) begin
                            rcv_expected = ev.seg_seq + 32'd1;
                            conn_code    = CODE_FIN_WAIT_2;
                        end
                    end else if (conn_code == CODE_FIN_WAIT_2 && !cfg_now.role_server) begin
                        if (is_fin) begin
                            rcv_expected = ev.seg_seq + 32'd1;
                            step_out[0]  = make_seg(FL_ACK, snd_next, rcv_expected,
                                                    cfg_now.local_port, remote_port_m,
                                                    ev.free_window);
                            n         = 1;
                            conn_code = CODE_CLOSED;
                        end
                    end else if (conn_code == CODE_CLOSING) begin
                        if (is_ack) conn_code = CODE_CLOSED;
                    end else if (conn_code == CODE_ESTABLISHED && cfg_now.role_server) begin
                        if (is_fin) begin
                            // passive close: ACK the peer FIN, then send our own
                            rcv_expected = ev.seg_seq + 32'd1;
                            step_out[0]  = make_seg(FL_ACK, snd_next, rcv_expected,
                                                    cfg_now.local_port, remote_port_m,
                                                    ev.free_window);
                            step_out[1]  = make_seg(FL_FIN, snd_next, rcv_expected,
                                                    cfg_now.local_port, remote_port_m,
                                                    SYN_WINDOW);
                            n         = 2;
                            conn_code = CODE_LAST_ACK;
                        end
                    end else if (conn_code == CODE_LAST_ACK && cfg_now.role_server) begin
                        if (is_ack) conn_code = CODE_CLOSED;
                    end
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            step_out[k].state_code = conn_code;
            step_out[k].last       = (k == n - 1);
        end
        step_count = n;
    endfunction

    // Mostly the event that moves the connection along, with random header content.
    function automatic event_t next_event(input bit noise);
        event_t     ev;
        logic [7:0] fin_any;
        ev      = make_event(2'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom,
                             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        fin_any = ($urandom_range(0, 1) != 0) ? FL_FIN : FL_FINACK;
        if (noise) return ev;
        ev.kind = KIND_SEGMENT;
        case (conn_code)
            CODE_CLOSED:
                ev.kind = ($urandom_range(0, 1) != 0) ? KIND_ACTIVE_OPEN : KIND_PASSIVE_OPEN;
            CODE_LISTEN:   ev.seg_flags = FL_SYN;
            CODE_SYN_SENT: ev.seg_flags = FL_SYNACK;
            CODE_SYN_RECV, CODE_CLOSING, CODE_LAST_ACK:
                ev.seg_flags = FL_ACK;
            CODE_ESTABLISHED: begin
                case ($urandom_range(0, 2))
                    0:       ev.seg_flags = FL_SYNACK;
                    1:       ev.kind      = KIND_ACTIVE_CLOSE;
                    default: ev.seg_flags = fin_any;
                endcase
            end
            CODE_FIN_WAIT_1: ev.seg_flags = ($urandom_range(0, 1) != 0) ? fin_any : FL_ACK;
            default:         ev.seg_flags = fin_any;
        endcase
        return ev;
    endfunction

    function automatic void add_row(input event_t ev, input int n_typed,
                                    input logic [3:0] state, input seg_t seg);
        plan_row_t r;
        r.ev      = ev;
        r.n_typed = n_typed;
        r.state   = state;
        r.seg     = seg;
        plan.push_back(r);
    endfunction

    // Hold the event until accepted, then record what it should send.
    task automatic drive_event(input event_t ev, input int n_typed,
                               input logic [3:0] state, input seg_t seg);
        int unsigned gap;
        if (events_sent % 32 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= ev.kind;
        s_seg_flags    <= ev.seg_flags;
        s_seg_seq      <= ev.seg_seq;
        s_seg_ack      <= ev.seg_ack;
        s_seg_src_port <= ev.seg_src_port;
        s_seg_dst_port <= ev.seg_dst_port;
        s_peer_port    <= ev.peer_port;
        s_free_window  <= ev.free_window;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        step_connection(ev);
        events_sent++;
        if (step_count == 2) pairs_seen++;
        if (n_typed == FROM_MODEL) begin
            for (int k = 0; k < step_count; k++) segs_due.push_back(step_out[k]);
        end else if (n_typed == 1) begin
            seg.state_code = state;
            seg.last       = 1'b1;
            segs_due.push_back(seg);
        end
    endtask

    task automatic configure(input cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_ROLE_SERVER;
        cfg_wdata <= {31'd0, c.role_server};
        @(posedge aclk);
        cfg_addr  <= REG_LOCAL_PORT;
        cfg_wdata <= {16'd0, c.local_port};
        @(posedge aclk);
        cfg_addr  <= REG_CLIENT_ISEQ;
        cfg_wdata <= c.client_iseq;
        @(posedge aclk);
        cfg_addr  <= REG_SERVER_ISEQ;
        cfg_wdata <= c.server_iseq;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_now = c;
    endtask

    // Drop valid, wait for every pending segment, then let the pipeline go quiet.
    task automatic settle();
        s_valid <= 1'b0;
        while (segs_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        seg_t want;
        if (segs_due.size() == 0) begin
            $error("unexpected segment: flags 0x%0h seq 0x%0h", m_out_flags, m_out_seq);
            errors++;
        end else begin
            want = segs_due.pop_front();
            check_field("out_flags", 32'(want.flags), 32'(m_out_flags));
            check_field("out_seq", want.seq, m_out_seq);
            check_field("out_ack", want.ack, m_out_ack);
            check_field("out_src_port", 32'(want.src_port), 32'(m_out_src_port));
            check_field("out_dst_port", 32'(want.dst_port), 32'(m_out_dst_port));
            check_field("out_window", 32'(want.window), 32'(m_out_window));
            check_field("conn_state_now", 32'(want.state_code), 32'(m_conn_state_now));
            check_field("last", 32'(want.last), 32'(m_last));
            segs_checked++;
        end
    endtask

    // result side: score each transaction and stall ready at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            check_result();
            if (segs_checked % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            rx_stall = rx_quiet ? 0 : $urandom_range(0, 7);
            if (rx_stall != 0) begin
                m_ready <= 1'b0;
                rx_hold <= rx_stall - 1;
            end
        end else if (!m_ready) begin
            if (rx_hold == 0) m_ready <= 1'b1;
            else rx_hold <= rx_hold - 1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tcp_connection_state_machine verification failed");
            $finish;
        end
    end

    initial begin
        cfg_t phase_cfg;
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_addr       <= REG_ROLE_SERVER;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_kind         <= KIND_SEGMENT;
        s_seg_flags    <= '0;
        s_seg_seq      <= '0;
        s_seg_ack      <= '0;
        s_seg_src_port <= '0;
        s_seg_dst_port <= '0;
        s_peer_port    <= '0;
        s_free_window  <= '0;

        cfg_now       = '{role_server: 1'b0, local_port: LOCAL_PORT_RESET,
                          client_iseq: '0, server_iseq: '0};
        conn_code     = CODE_CLOSED;
        remote_port_m = '0;
        rcv_expected  = '0;
        snd_next      = '0;

        // client open and close, then listen and close through CLOSING
        add_row(make_event(KIND_ACTIVE_CLOSE, 8'h00, '0, '0, '0, '0, '0, '0),
                0, CODE_CLOSED, '0);
        add_row(make_event(KIND_SEGMENT, FL_SYN, '0, '0, '0, '0, '0, '0),
                0, CODE_CLOSED, '0);
        add_row(make_event(KIND_ACTIVE_OPEN, 8'h00, '0, '0, '0, '0, 16'hFFFF, '0),
                1, CODE_SYN_SENT,
                make_seg(FL_SYN, 32'd0, 32'd0, LOCAL_PORT_RESET, 16'hFFFF, SYN_WINDOW));
        add_row(make_event(KIND_ACTIVE_OPEN, 8'h00, '0, '0, '0, '0, 16'd1, '0),
                0, CODE_SYN_SENT, '0);
        add_row(make_event(KIND_PASSIVE_OPEN, 8'h00, '0, '0, '0, '0, '0, '0),
                0, CODE_SYN_SENT, '0);
        add_row(make_event(KIND_SEGMENT, FL_ACK, '0, '0, '0, '0, '0, '0),
                0, CODE_SYN_SENT, '0);
        add_row(make_event(KIND_SEGMENT, FL_SYNACK, 32'hFFFF_FFFF, 32'd0, 16'd0, 16'hFFFF,
                           '0, '0),
                1, CODE_ESTABLISHED,
                make_seg(FL_ACK, 32'd0, 32'd0, 16'hFFFF, 16'd0, SYN_WINDOW));
        add_row(make_event(KIND_SEGMENT, FL_SYNACK, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0,
                           '0, '0),
                1, CODE_ESTABLISHED,
                make_seg(FL_ACK, 32'hFFFF_FFFF, 32'd1, 16'd0, 16'hFFFF, SYN_WINDOW));
        add_row(make_event(KIND_SEGMENT, FL_FIN, '0, '0, '0, '0, '0, '0),
                0, CODE_ESTABLISHED, '0);
        add_row(make_event(KIND_ACTIVE_CLOSE, 8'h00, '0, '0, '0, '0, '0, '0),
                1, CODE_FIN_WAIT_1,
                make_seg(FL_FIN, 32'd0, 32'd0, LOCAL_PORT_RESET, 16'hFFFF, SYN_WINDOW));
        add_row(make_event(KIND_ACTIVE_CLOSE, 8'h00, '0, '0, '0, '0, '0, '0),
                0, CODE_FIN_WAIT_1, '0);
        add_row(make_event(KIND_SEGMENT, FL_ACK, 32'h7FFF_FFFF, '0, '0, '0, '0, '0),
                0, CODE_FIN_WAIT_2, '0);
        add_row(make_event(KIND_SEGMENT, FL_FINACK, 32'hFFFF_FFFF, '0, '0, '0, '0, 16'hFFFF),
                1, CODE_CLOSED,
                make_seg(FL_ACK, 32'd1, 32'd0, LOCAL_PORT_RESET, 16'hFFFF, 16'hFFFF));
        add_row(make_event(KIND_PASSIVE_OPEN, 8'h00, '0, '0, '0, '0, '0, '0),
                0, CODE_LISTEN, '0);
        add_row(make_event(KIND_PASSIVE_OPEN, 8'h00, '0, '0, '0, '0, '0, '0),
                0, CODE_LISTEN, '0);
        add_row(make_event(KIND_SEGMENT, FL_SYNACK, '0, '0, '0, '0, '0, '0),
                0, CODE_LISTEN, '0);
        add_row(make_event(KIND_SEGMENT, FL_SYN, 32'hFFFF_FFFF, '0, 16'd1234, '0, '0, '0),
                1, CODE_SYN_RECV,
                make_seg(FL_SYNACK, 32'd0, 32'd0, LOCAL_PORT_RESET, 16'd1234, SYN_WINDOW));
        add_row(make_event(KIND_SEGMENT, FL_FIN, '0, '0, '0, '0, '0, '0),
                0, CODE_SYN_RECV, '0);
        add_row(make_event(KIND_SEGMENT, FL_ACK, '0, '0, '0, '0, '0, '0),
                FROM_MODEL, '0, '0);
        add_row(make_event(KIND_ACTIVE_CLOSE, 8'h00, '0, '0, '0, '0, '0, '0),
                FROM_MODEL, '0, '0);
        add_row(make_event(KIND_SEGMENT, FL_FIN, 32'd5, '0, '0, '0, '0, 16'd0),
                FROM_MODEL, '0, '0);
        add_row(make_event(KIND_SEGMENT, 8'hFF, '0, '0, '0, '0, '0, '0),
                0, CODE_CLOSING, '0);
        add_row(make_event(KIND_SEGMENT, FL_ACK, '0, '0, '0, '0, '0, '0),
                FROM_MODEL, '0, '0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) drive_event(plan[i].ev, plan[i].n_typed, plan[i].state, plan[i].seg);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            phase_cfg.role_server = 1'($urandom_range(0, 1));
            phase_cfg.local_port  = 16'($urandom);
            phase_cfg.client_iseq = $urandom;
            phase_cfg.server_iseq = $urandom;
            if (p == 0) phase_cfg = {1'b0, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000};
            else if (p == 1) phase_cfg = {1'b1, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF};
            else if (p == 2) phase_cfg.role_server = 1'b1;
            else if (p == 3) phase_cfg.role_server = 1'b0;
            configure(phase_cfg);
            for (int i = 0; i < PHASE_EVENTS; i++)
                drive_event(next_event($urandom_range(0, 99) < NOISE_PCT), FROM_MODEL, '0, '0);
            // close the connection so the next role setting starts from CLOSED
            for (int g = 0; g < 64 && conn_code != CODE_CLOSED; g++)
                drive_event(next_event(1'b0), FROM_MODEL, '0, '0);
            settle();
        end

        $display("Sent %0d events over %0d register settings; %0d segments scored,",
                 events_sent, PHASES + 1, segs_checked);
        $display("%0d events answered with an ACK and FIN pair.", pairs_seen);
        if (errors == 0) begin
            $display("tcp_connection_state_machine verification clean");
        end else begin
            $display("tcp_connection_state_machine verification failed");
        end
        $finish;
    end

endmodule
